>>> design/spq_pkg.sv
`default_nettype none

package spq_pkg;

  localparam int unsigned ValueBits = 32;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_PEEK   = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_INS  = 5'b00010,
    S_PUT  = 5'b00100,
    S_HEAD = 5'b01000,
    S_RESP = 5'b10000
  } state_e;

endpackage

`default_nettype wire

>>> design/spq_ram.sv
`default_nettype none

module spq_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> design/sorted_priority_queue.sv
// Channel  Direction  Handshake                 Beat contents
// in       input      in_valid_i / in_ready_o   op, item_value, item_priority
// out      output     out_valid_o / out_ready_i head_value, head_priority,
//                                               entry_count, status
//
// Entries live in one RAM as a ring: head pointer plus count, head at logical 0.
// Pop/peek: IDLE, HEAD, RESP. Full insert, empty pop/peek, unused op, insert into
// empty: IDLE straight to RESP. Other inserts: IDLE, INS, PUT, RESP; in INS each
// lower-priority entry moves one slot toward the tail, one per cycle on the RAM port.
// A new beat is taken only in IDLE; the output register holds a result while
// the next beat is being worked on. Reset empties the queue at once.
`default_nettype none

module sorted_priority_queue #(
  parameter int unsigned DEPTH         = 16,
  parameter int unsigned PRIORITY_BITS = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [1:0]                       op_i,
  input  wire logic signed [spq_pkg::ValueBits-1:0] item_value_i,
  input  wire logic [PRIORITY_BITS-1:0]         item_priority_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic signed [spq_pkg::ValueBits-1:0]  head_value_o,
  output logic [PRIORITY_BITS-1:0]              head_priority_o,
  output logic [$clog2(DEPTH+1)-1:0]            entry_count_o,
  output logic [1:0]                            status_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned VW = spq_pkg::ValueBits;
  localparam int unsigned EW = VW + PRIORITY_BITS;

  spq_pkg::state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] pos_q, pos_d;
  logic          pop_q, pop_d;
  logic [VW-1:0] val_q, val_d;
  logic [PRIORITY_BITS-1:0] pri_q, pri_d;

  logic [VW-1:0]            res_value_q, res_value_d;
  logic [PRIORITY_BITS-1:0] res_prio_q, res_prio_d;
  logic [CW-1:0]            res_count_q, res_count_d;
  logic [1:0]               res_status_q, res_status_d;

  logic                     out_valid_q, out_valid_d;
  logic [VW-1:0]            out_value_q;
  logic [PRIORITY_BITS-1:0] out_prio_q;
  logic [CW-1:0]            out_count_q;
  logic [1:0]               out_status_q;
  logic                     out_load;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;
  logic [PRIORITY_BITS-1:0] rd_pri;
  logic          in_fire;

  // logical slot -> physical RAM address
  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base, input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (AW+1)'(DEPTH)) begin
      return AW'(sum - (AW+1)'(DEPTH));
    end
    return AW'(sum);
  endfunction

  spq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_pri     = ram_rdata[PRIORITY_BITS-1:0];
  assign in_ready_o = (state_q == spq_pkg::S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    head_d       = head_q;
    pos_d        = pos_q;
    pop_d        = pop_q;
    val_d        = val_q;
    pri_d        = pri_q;
    res_value_d  = res_value_q;
    res_prio_d   = res_prio_q;
    res_count_d  = res_count_q;
    res_status_d = res_status_q;
    ram_we       = 1'b0;
    ram_waddr    = head_q;
    ram_wdata    = {val_q, pri_q};
    ram_re       = 1'b0;
    ram_raddr    = head_q;
    out_load     = 1'b0;

    case (state_q)
      spq_pkg::S_IDLE: begin
        if (in_fire) begin
          res_value_d  = '0;
          res_prio_d   = '0;
          res_count_d  = count_q;
          res_status_d = spq_pkg::STATUS_OK;
          state_d      = spq_pkg::S_RESP;
          case (op_i)
            spq_pkg::OP_INSERT: begin
              if (count_q == CW'(DEPTH)) begin
                res_status_d = spq_pkg::STATUS_FULL;
              end else if (count_q == '0) begin
                ram_we      = 1'b1;
                ram_waddr   = head_q;
                ram_wdata   = {item_value_i, item_priority_i};
                count_d     = count_q + CW'(1);
                res_count_d = count_q + CW'(1);
              end else begin
                // walk from the tail toward the head
                ram_re    = 1'b1;
                ram_raddr = wrap(head_q, AW'(count_q - CW'(1)));
                pos_d     = AW'(count_q - CW'(1));
                val_d     = item_value_i;
                pri_d     = item_priority_i;
                state_d   = spq_pkg::S_INS;
              end
            end
            spq_pkg::OP_POP, spq_pkg::OP_PEEK: begin
              if (count_q == '0) begin
                res_status_d = spq_pkg::STATUS_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = head_q;
                pop_d     = (op_i == spq_pkg::OP_POP);
                state_d   = spq_pkg::S_HEAD;
              end
            end
            default: begin
            end
          endcase
        end
      end

      spq_pkg::S_INS: begin
        if (rd_pri < pri_q) begin
          // stored entry moves back one slot
          ram_we    = 1'b1;
          ram_waddr = wrap(head_q, pos_q + AW'(1));
          ram_wdata = ram_rdata;
          if (pos_q == '0) begin
            state_d = spq_pkg::S_PUT;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = wrap(head_q, pos_q - AW'(1));
            pos_d     = pos_q - AW'(1);
          end
        end else begin
          pos_d   = pos_q + AW'(1);
          state_d = spq_pkg::S_PUT;
        end
      end

      spq_pkg::S_PUT: begin
        ram_we      = 1'b1;
        ram_waddr   = wrap(head_q, pos_q);
        ram_wdata   = {val_q, pri_q};
        count_d     = count_q + CW'(1);
        res_count_d = count_q + CW'(1);
        state_d     = spq_pkg::S_RESP;
      end

      spq_pkg::S_HEAD: begin
        res_value_d = ram_rdata[EW-1:PRIORITY_BITS];
        res_prio_d  = rd_pri;
        if (pop_q) begin
          head_d      = wrap(head_q, AW'(1));
          count_d     = count_q - CW'(1);
          res_count_d = count_q - CW'(1);
        end
        state_d = spq_pkg::S_RESP;
      end

      spq_pkg::S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = spq_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = spq_pkg::S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spq_pkg::S_IDLE;
      count_q     <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    pop_q        <= pop_d;
    val_q        <= val_d;
    pri_q        <= pri_d;
    res_value_q  <= res_value_d;
    res_prio_q   <= res_prio_d;
    res_count_q  <= res_count_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_value_q  <= res_value_q;
      out_prio_q   <= res_prio_q;
      out_count_q  <= res_count_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign head_value_o    = out_value_q;
  assign head_priority_o = out_prio_q;
  assign entry_count_o   = out_count_q;
  assign status_o        = out_status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("RAM read and write hit the same entry");

  a_out_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == spq_pkg::S_RESP))
    else $error("result beat raised outside response step");

  a_ins_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == spq_pkg::S_INS) |-> (count_q != '0 && count_q != CW'(DEPTH)))
    else $error("insert walk with no room or no entries");

  a_pop_reads_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && op_i == spq_pkg::OP_POP && count_q != '0) |=> (state_q == spq_pkg::S_HEAD))
    else $error("pop did not go to head read");

endmodule

`default_nettype wire
